[design/assert_macros.svh]
// assert_macros.svh: assertion shorthands shared by the rbes modules
// expects clk and rst_n to be declared in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every edge out of reset
`define CHK_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequence that must hold in the cycle after the trigger
`define CHK_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[design/rbes_pkg.sv]
// rbes_pkg: widths, codes and word types of the rigid body euler step pipeline
// no dependencies; imported by every rbes module and the top level
package rbes_pkg;

  // q16.16 word and field widths
  localparam int unsigned QW         = 32;
  localparam int unsigned FRAC       = 16;
  localparam int unsigned MASS_W     = 31;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned DAMP_W     = 16;
  localparam int unsigned DAMP_SHIFT = 12;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  // damping factor 1 - damp*dt, signed, wide enough for the negative range
  localparam int unsigned K_W = 2 * DAMP_W - DAMP_SHIFT + 1;
  localparam logic signed [K_W-1:0] K_ONE = K_W'(1 << FRAC);

  // one quotient bit per divider stage: 32 dividend bits plus 16 fraction bits
  localparam int unsigned DIV_STAGES = QW + FRAC;

  // lanes: horizontal, vertical, rotational
  localparam int unsigned N_LANE = 3;
  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Y = 1;
  localparam int unsigned LANE_W = 2;

  // body mode codes
  localparam logic [1:0] KIND_STATIC  = 2'd0;
  localparam logic [1:0] KIND_DYNAMIC = 2'd1;
  localparam int unsigned MODE_FIXED_ROT_BIT = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_DAMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_DAMP   = 2'd2;

  typedef logic signed [QW-1:0] q16_t;

  // configuration as seen by the datapath
  typedef struct packed {
    q16_t              gravity_y;
    logic [DAMP_W-1:0] lin_damp;
    logic [DAMP_W-1:0] ang_damp;
  } cfg_t;

  // one input word, forces/velocities/poses indexed by lane
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [MASS_W-1:0]  mass;
    q16_t [N_LANE-1:0]  frc;
    q16_t [N_LANE-1:0]  vel;
    q16_t [N_LANE-1:0]  pos;
    logic [DT_W-1:0]    dt;
  } body_t;

  // what travels alongside the dividers
  typedef struct packed {
    logic [1:0]             kind;
    logic                   fixed_rot;
    logic                   mass_zero;
    logic [N_LANE-1:0]      neg;
    logic [DT_W-1:0]        dt;
    logic signed [K_W-1:0]  k_lin;
    logic signed [K_W-1:0]  k_ang;
    q16_t [N_LANE-1:0]      vel;
    q16_t [N_LANE-1:0]      pos;
  } body_side_t;

endpackage

[design/rigid_body_euler_step.sv]
// rigid_body_euler_step: top level, config registers, flow control, output register
// depends on rbes_pkg, rbes_front, rbes_div, rbes_integ
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | body mode, mass, forces, velocities, pose, dt
//  out_    | output    | out_valid/out_stall| new velocities, spin, pose
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one word accepted per cycle while in_stall is low; on its way to out_valid a word
// passes the 48-stage restoring dividers plus 4 front and 5 integrate stages
// and the output register. all stages share one enable: when the output word
// is stalled the whole pipeline holds and in_stall rises in the same cycle.
// synchronous reset clears valid bits and sets all config registers to zero.
// cfg_ready is always high; a write takes effect on the next cycle.
module rigid_body_euler_step import rbes_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_body_mode,
  input  logic [MASS_W-1:0]    in_body_mass,
  input  logic signed [QW-1:0] in_force_x,
  input  logic signed [QW-1:0] in_force_y,
  input  logic signed [QW-1:0] in_torque_in,
  input  logic signed [QW-1:0] in_vel_x,
  input  logic signed [QW-1:0] in_vel_y,
  input  logic signed [QW-1:0] in_spin,
  input  logic signed [QW-1:0] in_pos_x,
  input  logic signed [QW-1:0] in_pos_y,
  input  logic signed [QW-1:0] in_angle,
  input  logic [DT_W-1:0]      in_delta_time,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [QW-1:0] out_new_vel_x,
  output logic signed [QW-1:0] out_new_vel_y,
  output logic signed [QW-1:0] out_new_spin,
  output logic signed [QW-1:0] out_new_pos_x,
  output logic signed [QW-1:0] out_new_pos_y,
  output logic signed [QW-1:0] out_new_angle,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QW-1:0]        cfg_data
);

  cfg_t                      cfg_r, cfg_nxt;
  logic                      en;
  body_t                     in_body;

  logic                      f_vld;
  body_side_t                f_side;
  logic [MASS_W-1:0]         f_mass;
  logic [N_LANE-1:0][QW-1:0] f_mag;
  logic                      q_vld;
  body_side_t                q_side;
  logic [N_LANE-1:0][QW-1:0] q_quo;
  logic                      r_vld;
  q16_t [N_LANE-1:0]         r_vel;
  q16_t [N_LANE-1:0]         r_pos;

  logic                      out_valid_r;
  q16_t [N_LANE-1:0]         out_vel_r;
  q16_t [N_LANE-1:0]         out_pos_r;

  // config register decode
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRAVITY_Y: cfg_nxt.gravity_y = q16_t'(cfg_data);
        CFG_LIN_DAMP:  cfg_nxt.lin_damp  = cfg_data[DAMP_W-1:0];
        CFG_ANG_DAMP:  cfg_nxt.ang_damp  = cfg_data[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline advances unless a finished word is held by the sink
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // gather the input word
  always_comb begin
    in_body.mode        = in_body_mode;
    in_body.mass        = in_body_mass;
    in_body.frc[LANE_X] = in_force_x;
    in_body.frc[LANE_Y] = in_force_y;
    in_body.frc[LANE_W] = in_torque_in;
    in_body.vel[LANE_X] = in_vel_x;
    in_body.vel[LANE_Y] = in_vel_y;
    in_body.vel[LANE_W] = in_spin;
    in_body.pos[LANE_X] = in_pos_x;
    in_body.pos[LANE_Y] = in_pos_y;
    in_body.pos[LANE_W] = in_angle;
    in_body.dt          = in_delta_time;
  end

  rbes_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_body (in_body),
    .cfg     (cfg_r),
    .f_vld   (f_vld),
    .f_side  (f_side),
    .f_mass  (f_mass),
    .f_mag   (f_mag)
  );

  rbes_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .d_vld  (f_vld),
    .d_side (f_side),
    .d_mass (f_mass),
    .d_mag  (f_mag),
    .q_vld  (q_vld),
    .q_side (q_side),
    .q_quo  (q_quo)
  );

  rbes_integ u_integ (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .q_vld  (q_vld),
    .q_side (q_side),
    .q_quo  (q_quo),
    .r_vld  (r_vld),
    .r_vel  (r_vel),
    .r_pos  (r_pos)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vel_r <= r_vel;
      out_pos_r <= r_pos;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_vel_x = out_vel_r[LANE_X];
  assign out_new_vel_y = out_vel_r[LANE_Y];
  assign out_new_spin  = out_vel_r[LANE_W];
  assign out_new_pos_x = out_pos_r[LANE_X];
  assign out_new_pos_y = out_pos_r[LANE_Y];
  assign out_new_angle = out_pos_r[LANE_W];

endmodule

[design/rbes_front.sv]
// rbes_front: input capture, gravity force, damping factors, force magnitudes
// depends on rbes_pkg; feeds rbes_div
module rbes_front import rbes_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  body_t                       in_body,
  input  cfg_t                        cfg,
  output logic                        f_vld,
  output body_side_t                  f_side,
  output logic [MASS_W-1:0]           f_mass,
  output logic [N_LANE-1:0][QW-1:0]   f_mag
);

  `include "assert_macros.svh"

  logic                      s0_vld_r;
  body_t                     s0_body_r;
  logic                      s1_vld_r;
  body_t                     s1_body_r;
  q16_t                      s1_grav_r;
  logic [2*DAMP_W-1:0]       s1_dl_r;
  logic [2*DAMP_W-1:0]       s1_da_r;
  logic                      s2_vld_r;
  body_t                     s2_body_r;
  logic signed [K_W-1:0]     s2_kl_r;
  logic signed [K_W-1:0]     s2_ka_r;
  logic                      s3_vld_r;
  body_side_t                s3_side_r;
  logic [MASS_W-1:0]         s3_mass_r;
  logic [N_LANE-1:0][QW-1:0] s3_mag_r;

  logic signed [2*QW-1:0]    grav_prod;
  logic [2*DAMP_W-1:0]       dl_nxt;
  logic [2*DAMP_W-1:0]       da_nxt;
  body_t                     s2_body_nxt;
  logic signed [K_W-1:0]     kl_nxt;
  logic signed [K_W-1:0]     ka_nxt;
  body_side_t                s3_side_nxt;
  logic [N_LANE-1:0][QW-1:0] mag_nxt;
  logic                      mag_ok;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_vld;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // stage 1: mass * gravity and damping * dt products
  always_comb begin
    grav_prod = $signed({1'b0, s0_body_r.mass}) * cfg.gravity_y;
    dl_nxt    = s0_body_r.dt * cfg.lin_damp;
    da_nxt    = s0_body_r.dt * cfg.ang_damp;
  end

  // stage 2: gravity into vertical force for dynamic bodies, damping factors
  always_comb begin
    s2_body_nxt = s1_body_r;
    if (s1_body_r.mode[1:0] == KIND_DYNAMIC) begin
      s2_body_nxt.frc[LANE_Y] = q16_t'($signed(s1_body_r.frc[LANE_Y]) + s1_grav_r);
    end
    kl_nxt = K_ONE - $signed({1'b0, s1_dl_r[2*DAMP_W-1:DAMP_SHIFT]});
    ka_nxt = K_ONE - $signed({1'b0, s1_da_r[2*DAMP_W-1:DAMP_SHIFT]});
  end

  // stage 3: split forces into sign and magnitude for the dividers
  always_comb begin
    s3_side_nxt.kind      = s2_body_r.mode[1:0];
    s3_side_nxt.fixed_rot = s2_body_r.mode[MODE_FIXED_ROT_BIT];
    s3_side_nxt.mass_zero = (s2_body_r.mass == '0);
    s3_side_nxt.dt        = s2_body_r.dt;
    s3_side_nxt.k_lin     = s2_kl_r;
    s3_side_nxt.k_ang     = s2_ka_r;
    s3_side_nxt.vel       = s2_body_r.vel;
    s3_side_nxt.pos       = s2_body_r.pos;
    for (int l = 0; l < N_LANE; l++) begin
      s3_side_nxt.neg[l] = s2_body_r.frc[l][QW-1];
      mag_nxt[l]         = s2_body_r.frc[l][QW-1] ? QW'(-s2_body_r.frc[l])
                                                  : s2_body_r.frc[l];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s0_body_r <= in_body;
      s1_body_r <= s0_body_r;
      s1_grav_r <= q16_t'(grav_prod[QW+FRAC-1:FRAC]);
      s1_dl_r   <= dl_nxt;
      s1_da_r   <= da_nxt;
      s2_body_r <= s2_body_nxt;
      s2_kl_r   <= kl_nxt;
      s2_ka_r   <= ka_nxt;
      s3_side_r <= s3_side_nxt;
      s3_mass_r <= s2_body_r.mass;
      s3_mag_r  <= mag_nxt;
    end
  end

  assign f_vld  = s3_vld_r;
  assign f_side = s3_side_r;
  assign f_mass = s3_mass_r;
  assign f_mag  = s3_mag_r;

  // a magnitude with its top bit set can only come from the most negative force
  always_comb begin
    mag_ok = 1'b1;
    for (int l = 0; l < N_LANE; l++) begin
      if (s3_mag_r[l][QW-1] && ((s3_mag_r[l][QW-2:0] != '0) || !s3_side_r.neg[l])) begin
        mag_ok = 1'b0;
      end
    end
  end

  `CHK_ALWAYS(a_mag_range, !s3_vld_r || mag_ok, "force magnitude out of range")

endmodule

[design/rbes_div.sv]
// rbes_div: three pipelined restoring dividers, one quotient bit per stage
// depends on rbes_pkg; fed by rbes_front, feeds rbes_integ
module rbes_div import rbes_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        d_vld,
  input  body_side_t                  d_side,
  input  logic [MASS_W-1:0]           d_mass,
  input  logic [N_LANE-1:0][QW-1:0]   d_mag,
  output logic                        q_vld,
  output body_side_t                  q_side,
  output logic [N_LANE-1:0][QW-1:0]   q_quo
);

  `include "assert_macros.svh"

  localparam int unsigned LAST = DIV_STAGES - 1;

  logic                          vld_r  [DIV_STAGES];
  body_side_t                    side_r [DIV_STAGES];
  logic [MASS_W-1:0]             mass_r [DIV_STAGES];
  logic [N_LANE-1:0][QW-1:0]     num_r  [DIV_STAGES];
  logic [N_LANE-1:0][QW-1:0]     quo_r  [DIV_STAGES];
  logic [N_LANE-1:0][MASS_W-1:0] rem_r  [DIV_STAGES];
  logic                          rem_ok;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                          src_vld;
    body_side_t                    src_side;
    logic [MASS_W-1:0]             src_mass;
    logic [N_LANE-1:0][QW-1:0]     src_num;
    logic [N_LANE-1:0][QW-1:0]     src_quo;
    logic [N_LANE-1:0][MASS_W-1:0] src_rem;
    logic [N_LANE-1:0][QW-1:0]     trial;
    logic [N_LANE-1:0]             ge;
    logic [N_LANE-1:0][MASS_W-1:0] rem_nxt;
    logic [N_LANE-1:0][QW-1:0]     num_nxt;
    logic [N_LANE-1:0][QW-1:0]     quo_nxt;

    // stage source: fresh word or the previous stage
    if (s == 0) begin : g_first
      assign src_vld  = d_vld;
      assign src_side = d_side;
      assign src_mass = d_mass;
      assign src_num  = d_mag;
      assign src_quo  = '0;
      assign src_rem  = '0;
    end else begin : g_next
      assign src_vld  = vld_r[s-1];
      assign src_side = side_r[s-1];
      assign src_mass = mass_r[s-1];
      assign src_num  = num_r[s-1];
      assign src_quo  = quo_r[s-1];
      assign src_rem  = rem_r[s-1];
    end

    // bring down the next dividend bit, subtract when it fits
    always_comb begin
      for (int l = 0; l < N_LANE; l++) begin
        trial[l]   = {src_rem[l], src_num[l][QW-1]};
        ge[l]      = (trial[l] >= {1'b0, src_mass});
        rem_nxt[l] = ge[l] ? MASS_W'(trial[l] - {1'b0, src_mass}) : trial[l][MASS_W-1:0];
        num_nxt[l] = {src_num[l][QW-2:0], 1'b0};
        quo_nxt[l] = {src_quo[l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= src_side;
        mass_r[s] <= src_mass;
        num_r[s]  <= num_nxt;
        quo_r[s]  <= quo_nxt;
        rem_r[s]  <= rem_nxt;
      end
    end
  end

  assign q_vld  = vld_r[LAST];
  assign q_side = side_r[LAST];
  assign q_quo  = quo_r[LAST];

  // final remainder stays below the divisor
  always_comb begin
    rem_ok = 1'b1;
    for (int l = 0; l < N_LANE; l++) begin
      if (rem_r[LAST][l] >= mass_r[LAST]) begin
        rem_ok = 1'b0;
      end
    end
  end

  `CHK_ALWAYS(a_rem_bound, !vld_r[LAST] || side_r[LAST].mass_zero || rem_ok, "divider remainder not below divisor")

endmodule

[design/rbes_integ.sv]
// rbes_integ: signed acceleration, velocity update, damping, position update
// depends on rbes_pkg; fed by rbes_div, result goes to the top output register
module rbes_integ import rbes_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      q_vld,
  input  body_side_t                q_side,
  input  logic [N_LANE-1:0][QW-1:0] q_quo,
  output logic                      r_vld,
  output q16_t [N_LANE-1:0]         r_vel,
  output q16_t [N_LANE-1:0]         r_pos
);

  `include "assert_macros.svh"

  logic                s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  body_side_t          s0_side_r, s1_side_r, s2_side_r, s3_side_r, s4_side_r;
  q16_t [N_LANE-1:0]   acc_r;
  q16_t [N_LANE-1:0]   dv_r;
  q16_t [N_LANE-1:0]   v1_r;
  q16_t [N_LANE-1:0]   v2_r;
  q16_t [N_LANE-1:0]   v2_d_r;
  q16_t [N_LANE-1:0]   dp_r;

  q16_t [N_LANE-1:0]          acc_nxt;
  logic signed [QW+DT_W:0]    dv_prod [N_LANE];
  q16_t [N_LANE-1:0]          v1_nxt;
  logic signed [QW+K_W-1:0]   dmp_prod [N_LANE];
  logic signed [QW+DT_W:0]    dp_prod [N_LANE];
  q16_t [N_LANE-1:0]          pos_nxt;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= q_vld;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // stage 0: restore sign of the quotient, zero mass gives no acceleration
  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      if (q_side.mass_zero) begin
        acc_nxt[l] = '0;
      end else if (q_side.neg[l]) begin
        acc_nxt[l] = q16_t'(-q_quo[l]);
      end else begin
        acc_nxt[l] = q16_t'(q_quo[l]);
      end
    end
  end

  // stages 1..4: acc*dt, add to velocity, damping, velocity*dt
  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      dv_prod[l]  = $signed(acc_r[l]) * $signed({1'b0, s0_side_r.dt});
      v1_nxt[l]   = q16_t'($signed(s1_side_r.vel[l]) + $signed(dv_r[l]));
      dmp_prod[l] = $signed(v1_r[l])
                    * ((l == LANE_W) ? s2_side_r.k_ang : s2_side_r.k_lin);
      dp_prod[l]  = $signed(v2_r[l]) * $signed({1'b0, s3_side_r.dt});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= q_side;
      s1_side_r <= s0_side_r;
      s2_side_r <= s1_side_r;
      s3_side_r <= s2_side_r;
      s4_side_r <= s3_side_r;
      acc_r     <= acc_nxt;
      v1_r      <= v1_nxt;
      v2_d_r    <= v2_r;
      for (int l = 0; l < N_LANE; l++) begin
        dv_r[l] <= q16_t'(dv_prod[l][QW+FRAC-1:FRAC]);
        v2_r[l] <= q16_t'(dmp_prod[l][QW+FRAC-1:FRAC]);
        dp_r[l] <= q16_t'(dp_prod[l][QW+FRAC-1:FRAC]);
      end
    end
  end

  // final add and pass-through selection for static and fixed-rotation bodies
  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      pos_nxt[l] = q16_t'($signed(s4_side_r.pos[l]) + $signed(dp_r[l]));
    end
    if (s4_side_r.kind == KIND_STATIC) begin
      r_vel = s4_side_r.vel;
      r_pos = s4_side_r.pos;
    end else begin
      r_vel = v2_d_r;
      r_pos = pos_nxt;
      if (s4_side_r.fixed_rot) begin
        r_pos[LANE_W] = s4_side_r.pos[LANE_W];
      end
    end
  end

  assign r_vld = s4_vld_r;

  `CHK_NEXT(a_zero_mass_acc, en && q_vld && q_side.mass_zero, acc_r == '0, "nonzero acceleration for zero mass")

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for rigid_body_euler_step, body state words in, new state out
// depends on rbes_pkg and the rigid_body_euler_step design files
module tb_top;
  import rbes_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_WORDS  = 218;
  localparam int unsigned PIPE_DEPTH  = 64;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // one body record as it enters the block
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [MASS_W-1:0] mass;
    q16_t              fx, fy, tq;
    q16_t              vx, vy, w;
    q16_t              px, py, ang;
    logic [DT_W-1:0]   dt;
  } body_word_t;

  // updated state of one body
  typedef struct {
    q16_t vel_x, vel_y, spin;
    q16_t pos_x, pos_y, angle;
  } state_word_t;

  // euler step predictor and store of expected states
  class euler_step_board;
    state_word_t pending_states[$];
    longint      gravity_y;
    longint      lin_damp;
    longint      ang_damp;
    int unsigned n_fail;

    function new();
      gravity_y = 0;
      lin_damp  = 0;
      ang_damp  = 0;
      n_fail    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [QW-1:0] data);
      q16_t g;
      g = data;
      case (idx)
        CFG_GRAVITY_Y: gravity_y = g;
        CFG_LIN_DAMP:  lin_damp  = data[DAMP_W-1:0];
        CFG_ANG_DAMP:  ang_damp  = data[DAMP_W-1:0];
        default: ;
      endcase
    endfunction

    function longint wrap32(longint x);
      int t;
      t = int'(x);
      return t;
    endfunction

    // 1 - damping*dt in q16.16, may go negative
    function longint damp_scale(longint damp, longint dt);
      return 65536 - ((damp * dt) >>> DAMP_SHIFT);
    endfunction

    // force over mass, truncating division; massless bodies get none
    function longint accel(longint f, longint mass);
      if (mass == 0) return 0;
      return wrap32((f * 65536) / mass);
    endfunction

    function longint settle_vel(longint v, longint acc, longint dt, longint k);
      longint v1;
      v1 = wrap32(v + ((acc * dt) >>> FRAC));
      return wrap32((v1 * k) >>> FRAC);
    endfunction

    function longint advance(longint p, longint v, longint dt);
      return wrap32(p + ((v * dt) >>> FRAC));
    endfunction

    function state_word_t step_body(body_word_t b);
      state_word_t r;
      longint dt, mass, k_lin, k_ang, fy, vx, vy, w;
      // static bodies pass through
      if (b.mode[1:0] == KIND_STATIC) begin
        r.vel_x = b.vx;
        r.vel_y = b.vy;
        r.spin  = b.w;
        r.pos_x = b.px;
        r.pos_y = b.py;
        r.angle = b.ang;
        return r;
      end
      dt    = b.dt;
      mass  = b.mass;
      k_lin = damp_scale(lin_damp, dt);
      k_ang = damp_scale(ang_damp, dt);
      fy    = b.fy;
      // gravity only pulls on dynamic bodies
      if (b.mode[1:0] == KIND_DYNAMIC) fy = wrap32(fy + ((mass * gravity_y) >>> FRAC));
      vx = settle_vel(b.vx, accel(b.fx, mass), dt, k_lin);
      vy = settle_vel(b.vy, accel(fy, mass), dt, k_lin);
      w  = settle_vel(b.w, accel(b.tq, mass), dt, k_ang);
      r.vel_x = q16_t'(vx);
      r.vel_y = q16_t'(vy);
      r.spin  = q16_t'(w);
      r.pos_x = q16_t'(advance(b.px, vx, dt));
      r.pos_y = q16_t'(advance(b.py, vy, dt));
      if (b.mode[MODE_FIXED_ROT_BIT]) r.angle = b.ang;
      else r.angle = q16_t'(advance(b.ang, w, dt));
      return r;
    endfunction

    function void note_body(body_word_t b);
      pending_states.push_back(step_body(b));
    endfunction

    function void compare_field(string field, q16_t want, q16_t got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        n_fail++;
      end
    endfunction

    function void check_state(state_word_t got);
      state_word_t want;
      if (pending_states.size() == 0) begin
        $error("state word out with no body waiting");
        n_fail++;
        return;
      end
      want = pending_states.pop_front();
      compare_field("new_vel_x", want.vel_x, got.vel_x);
      compare_field("new_vel_y", want.vel_y, got.vel_y);
      compare_field("new_spin",  want.spin,  got.spin);
      compare_field("new_pos_x", want.pos_x, got.pos_x);
      compare_field("new_pos_y", want.pos_y, got.pos_y);
      compare_field("new_angle", want.angle, got.angle);
    endfunction

    function int unsigned pending();
      return pending_states.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_body_mode;
  logic [MASS_W-1:0]    in_body_mass;
  logic signed [QW-1:0] in_force_x, in_force_y, in_torque_in;
  logic signed [QW-1:0] in_vel_x, in_vel_y, in_spin;
  logic signed [QW-1:0] in_pos_x, in_pos_y, in_angle;
  logic [DT_W-1:0]      in_delta_time;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [QW-1:0] out_new_vel_x, out_new_vel_y, out_new_spin;
  logic signed [QW-1:0] out_new_pos_x, out_new_pos_y, out_new_angle;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [QW-1:0]        cfg_data;

  euler_step_board board;
  idle_mode_e      idle_mode;
  int unsigned     cycle_count = 0;

  rigid_body_euler_step u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_body_mode  (in_body_mode),
    .in_body_mass  (in_body_mass),
    .in_force_x    (in_force_x),
    .in_force_y    (in_force_y),
    .in_torque_in  (in_torque_in),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_spin       (in_spin),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_angle      (in_angle),
    .in_delta_time (in_delta_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_new_vel_x (out_new_vel_x),
    .out_new_vel_y (out_new_vel_y),
    .out_new_spin  (out_new_spin),
    .out_new_pos_x (out_new_pos_x),
    .out_new_pos_y (out_new_pos_y),
    .out_new_angle (out_new_angle),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    int unsigned pct;
    pct = (idle_mode == IDLE_RECEIVER) ? 63 : (idle_mode == IDLE_BOTH) ? 18 : 0;
    out_stall <= ($urandom_range(99) < pct);
  end

  // monitor: note accepted bodies, check accepted state words
  always @(posedge clk) begin
    body_word_t  seen;
    state_word_t got;
    if (rst_n && in_valid && !in_stall) begin
      seen.mode = in_body_mode;
      seen.mass = in_body_mass;
      seen.fx   = in_force_x;
      seen.fy   = in_force_y;
      seen.tq   = in_torque_in;
      seen.vx   = in_vel_x;
      seen.vy   = in_vel_y;
      seen.w    = in_spin;
      seen.px   = in_pos_x;
      seen.py   = in_pos_y;
      seen.ang  = in_angle;
      seen.dt   = in_delta_time;
      board.note_body(seen);
    end
    if (rst_n && out_valid && !out_stall) begin
      got.vel_x = out_new_vel_x;
      got.vel_y = out_new_vel_y;
      got.spin  = out_new_spin;
      got.pos_x = out_new_pos_x;
      got.pos_y = out_new_pos_y;
      got.angle = out_new_angle;
      board.check_state(got);
    end
  end

  function automatic body_word_t make_body(logic [MODE_W-1:0] mode, logic [MASS_W-1:0] mass,
                                           q16_t fx, q16_t fy, q16_t tq,
                                           q16_t vx, q16_t vy, q16_t w,
                                           q16_t px, q16_t py, q16_t ang,
                                           logic [DT_W-1:0] dt);
    body_word_t b;
    b.mode = mode;
    b.mass = mass;
    b.fx   = fx;
    b.fy   = fy;
    b.tq   = tq;
    b.vx   = vx;
    b.vy   = vy;
    b.w    = w;
    b.px   = px;
    b.py   = py;
    b.ang  = ang;
    b.dt   = dt;
    return b;
  endfunction

  // extremes, zero and small signed values, and full random words
  function automatic q16_t rand_q16();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4, 5: return q16_t'(int'($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // start at a falling edge, return at a falling edge once the word is taken
  task automatic send_body(body_word_t b);
    int unsigned pct;
    pct = (idle_mode == IDLE_SENDER) ? 63 : (idle_mode == IDLE_BOTH) ? 18 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_body_mode  <= b.mode;
    in_body_mass  <= b.mass;
    in_force_x    <= b.fx;
    in_force_y    <= b.fy;
    in_torque_in  <= b.tq;
    in_vel_x      <= b.vx;
    in_vel_y      <= b.vy;
    in_spin       <= b.w;
    in_pos_x      <= b.px;
    in_pos_y      <= b.py;
    in_angle      <= b.ang;
    in_delta_time <= b.dt;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [QW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_regs(logic [QW-1:0] g, logic [DAMP_W-1:0] ld, logic [DAMP_W-1:0] ad);
    write_reg(CFG_GRAVITY_Y, g);
    write_reg(CFG_LIN_DAMP, {16'h0, ld});
    write_reg(CFG_ANG_DAMP, {16'h0, ad});
  endtask

  // wait until every expected state word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  task automatic run_directed();
    // static bodies at both extremes, with and without fixed rotation
    send_body(make_body(3'd0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
    send_body(make_body(3'd4, 31'h1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 16'h0));
    // unit mass, unit forces, half second
    send_body(make_body(3'd1, 31'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                        '0, '0, '0, '0, '0, '0, 16'h8000));
    // smallest mass and largest force: acceleration wraps
    send_body(make_body(3'd1, 31'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 32'h0010_0000,
                        32'hFFF0_0000, 32'h0000_4000, 16'hFFFF));
    // largest mass, most negative force
    send_body(make_body(3'd1, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
    // kinematic bodies, with and without fixed rotation
    send_body(make_body(3'd2, 31'h2_0000, 32'h0004_0000, 32'hFFFC_0000, 32'h0002_0000,
                        32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0100_0000,
                        32'h0200_0000, 32'h0003_2000, 16'h1000));
    send_body(make_body(3'd7, 31'h0_8000, 32'hFFFE_0000, 32'h0005_0000, 32'hFFF0_0000,
                        32'hFFFF_8000, 32'h0000_8000, 32'h0004_0000, 32'hFF00_0000,
                        32'h0080_0000, 32'hFFFE_0000, 16'h4000));
    send_body(make_body(3'd3, 31'h3_0000, 32'h0009_0000, 32'h0001_0000, 32'h0006_0000,
                        32'h0100_0000, 32'hFF00_0000, 32'h0020_0000, '0, '0, '0, 16'hC000));
    // dynamic body with fixed rotation
    send_body(make_body(3'd5, 31'h1_0000, 32'h0002_0000, 32'h0003_0000, 32'h0007_0000,
                        32'h0001_0000, '0, 32'h0002_0000, 32'h0000_1000, 32'h0000_2000,
                        32'h0001_0000, 16'h2000));
    // massless bodies: no acceleration from force, torque or gravity
    send_body(make_body(3'd1, 31'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                        32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0000_1000,
                        32'h0000_2000, 32'h0000_3000, 16'h8000));
    send_body(make_body(3'd6, 31'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                        32'h0003_0000, 32'h0004_0000, 32'h0005_0000, '0, '0, '0, 16'hFFFF));
    // zero time step
    send_body(make_body(3'd1, 31'h1_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                        32'h0001_0000, 32'h0001_0000, 16'h0));
  endtask

  // directed words, then random phases over idle patterns and register settings
  initial begin
    body_word_t  b;
    logic [QW-1:0] g;
    logic [DAMP_W-1:0] ld, ad;
    board         = new();
    idle_mode     = IDLE_NONE;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_body_mode  = '0;
    in_body_mass  = '0;
    in_force_x    = '0;
    in_force_y    = '0;
    in_torque_in  = '0;
    in_vel_x      = '0;
    in_vel_y      = '0;
    in_spin       = '0;
    in_pos_x      = '0;
    in_pos_y      = '0;
    in_angle      = '0;
    in_delta_time = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed set at reset values, then at extreme settings
    run_directed();
    drain();
    write_regs(32'h8000_0000, 16'hFFFF, 16'hFFFF);
    run_directed();
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p / 2)
        0: begin g = -32'sd642908;      ld = 16'd410;  ad = 16'd205;  end
        1: begin g = 32'h7FFF_FFFF;     ld = 16'hFFFF; ad = 16'h0;    end
        2: begin g = 32'h8000_0000;     ld = 16'h0;    ad = 16'hFFFF; end
        default: begin
          g  = $urandom;
          ld = DAMP_W'($urandom_range(16'hFFFF));
          ad = DAMP_W'($urandom_range(16'hFFFF));
        end
      endcase
      write_regs(g, ld, ad);
      idle_mode = idle_mode_e'(p % 4);
      for (int i = 0; i < RAND_WORDS; i++) begin
        b.mode = MODE_W'($urandom_range(7));
        case ($urandom_range(7))
          0: b.mass = 31'h1;
          1: b.mass = 31'h7FFF_FFFF;
          2, 3, 4: b.mass = MASS_W'($urandom_range(32'h00FF_FFFF, 1));
          default: b.mass = MASS_W'($urandom_range(32'h7FFF_FFFF, 1));
        endcase
        b.fx  = rand_q16();
        b.fy  = rand_q16();
        b.tq  = rand_q16();
        b.vx  = rand_q16();
        b.vy  = rand_q16();
        b.w   = rand_q16();
        b.px  = rand_q16();
        b.py  = rand_q16();
        b.ang = rand_q16();
        case ($urandom_range(7))
          0: b.dt = '0;
          1: b.dt = 16'hFFFF;
          default: b.dt = DT_W'($urandom_range(16'hFFFF));
        endcase
        send_body(b);
      end
      drain();
    end

    // let anything stray surface
    idle_mode = IDLE_NONE;
    repeat (PIPE_DEPTH) @(negedge clk);
    if (board.n_fail == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
